/* rtl/bptc_pkg.sv */
// ============================================================================
// Barometric compensation package
// Shared widths, register indices and scale-factor tables for the pressure
// and temperature compensation pipeline.
// ============================================================================
package bptc_pkg;

    // Port and register widths
    localparam int CODE_W  = 3;
    localparam int RAW_W   = 24;
    localparam int OUT_W   = 32;
    localparam int DATA_W  = 64;
    localparam int APB_AW  = 6;
    localparam int IDX_LSB = 3;

    localparam int C0_W    = 12;
    localparam int C00_W   = 20;
    localparam int COEF_W  = 16;

    // Scaling datapath
    localparam int MAG_W       = 24;
    localparam int RECIP_W     = 31;
    localparam int RECIP_SHIFT = 32;
    localparam int PROD_W      = MAG_W + RECIP_W;
    localparam int QUO_W       = 24;
    localparam int REM_W       = 8;
    localparam int DIFF_W      = 32;
    localparam int FRAC_W      = 11;
    localparam int COARSE_F_W  = 5;
    localparam int SMAG_W      = 30;
    localparam int FINE_A_W    = SMAG_W - FRAC_W;
    localparam int SC_W        = 32;

    // Polynomial datapath
    localparam int SQ_W      = 64;
    localparam int PC10_W    = 52;
    localparam int P16_W     = 48;
    localparam int TC1_W     = 44;
    localparam int W_W       = 48;
    localparam int LIN_W     = 52;
    localparam int TV_W      = 44;
    localparam int SPLIT     = 30;
    localparam int W_SPLIT   = 24;
    localparam int TPC_W     = 80;
    localparam int PP_W      = 56;
    localparam int ACC_W     = 112;
    localparam int ACC_SHIFT = 66;
    localparam int Q_W       = ACC_W - ACC_SHIFT;
    localparam int FRAC_SH   = 24;
    localparam int TEMP_ALIGN = 23;
    localparam int TEMP_SHIFT = 16;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Register map, one register every eight bytes
    typedef enum logic [2:0] {
        REG_PRESS_OSR = 3'd0,
        REG_TEMP_OSR  = 3'd1,
        REG_T_OFFSET  = 3'd2,
        REG_T_SLOPE   = 3'd3,
        REG_P_OFFSET  = 3'd4,
        REG_P_LINEAR  = 3'd5,
        REG_P_CROSS   = 3'd6,
        REG_P_CUBIC   = 3'd7
    } reg_idx_t;

    localparam logic [CODE_W-1:0] OSR_RESET = 3'd3;
    localparam logic [CODE_W-1:0] CODE_UNIT = 3'd0;

    // Every scale factor is (2^k - 1) times a power of two. The division by
    // 2^k - 1 of a 24-bit magnitude is exact with the multiplier ceil(2^32/d).
    localparam logic [RECIP_W-1:0] RECIP_TAB [8] = '{
        31'd0,          31'd1431655766, 31'd613566757, 31'd286331154,
        31'd138547333,  31'd68174085,   31'd33818641,  31'd16843010
    };

    localparam logic [3:0] LOG_TAB [8] = '{
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8
    };

    // The four finest codes shift the raw value by eleven bits, the others by five.
    function automatic logic fine_step(input logic [CODE_W-1:0] code);
        fine_step = code[CODE_W-1];
    endfunction

    // floor(r * 2^s / (2^k - 1)) for r < 2^k - 1: the leading s bits of the
    // base-2^k repeating fraction 0.rrr...
    function automatic logic [FRAC_W-1:0] frac_bits(input logic [CODE_W-1:0] code,
                                                    input logic [REM_W-1:0] r);
        logic [FRAC_W-1:0] f;
        f = '0;
        case (code)
            3'd1:    f = FRAC_W'({r[1:0], r[1:0], r[1]});
            3'd2:    f = FRAC_W'({r[2:0], r[2:1]});
            3'd3:    f = FRAC_W'({r[3:0], r[3]});
            3'd4:    f = FRAC_W'({r[4:0], r[4:0], r[4]});
            3'd5:    f = FRAC_W'({r[5:0], r[5:1]});
            3'd6:    f = FRAC_W'({r[6:0], r[6:3]});
            3'd7:    f = FRAC_W'({r[7:0], r[7:5]});
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

/* rtl/baro_pressure_temp_compensation.sv */
// ============================================================================
// Barometric pressure and temperature compensation
// Pipelined calibration polynomial: one raw sample pair in, one compensated
// temperature and pressure word out.
// ============================================================================
// Usage
//   The s_ channel takes a word holding a raw 24-bit temperature and pressure
//   pair; the m_ channel returns the compensated temperature (1/256 degree C),
//   pressure (1/64 Pa) and a clipped flag that is set when the pressure had to
//   be saturated to 32 bits. Both channels use a valid/ready handshake.
//   Calibration coefficients and the two oversampling codes sit behind the
//   APB port, eight 64-bit registers at byte addresses 0, 8, ... 56. They
//   should only be written while no word is in flight.
//   Throughput is one word per clock cycle while the output is not stalled:
//   every multiplier and wide adder has a register stage of its own, so a
//   new pair may enter on every edge at which s_ready is high. m_valid rises
//   once a word has passed ten datapath stages and the output register.
//   A synchronous active-low reset empties the pipeline, sets both oversample
//   codes to 3 and clears all coefficients.
//   When the receiver holds m_ready low with a word waiting, the whole
//   pipeline freezes and s_ready falls; nothing is dropped or duplicated, and
//   a word can still be accepted while the output slot is being emptied.
// ============================================================================
module baro_pressure_temp_compensation (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [bptc_pkg::RAW_W-1:0]   s_raw_temp,
    input  logic signed [bptc_pkg::RAW_W-1:0]   s_raw_press,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bptc_pkg::OUT_W-1:0]   m_temperature,
    output logic signed [bptc_pkg::OUT_W-1:0]   m_pressure,
    output logic                                m_clipped,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bptc_pkg::APB_AW-1:0]         paddr,
    input  logic [bptc_pkg::DATA_W-1:0]         pwdata,
    output logic [bptc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    localparam int STAGES = 10;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [bptc_pkg::CODE_W-1:0] press_osr_reg;
    logic [bptc_pkg::CODE_W-1:0] temp_osr_reg;
    logic [bptc_pkg::C0_W-1:0]   c0_reg;
    logic [bptc_pkg::C0_W-1:0]   c1_reg;
    logic [bptc_pkg::C00_W-1:0]  c00_reg;
    logic [bptc_pkg::C00_W-1:0]  c10_reg;
    logic [bptc_pkg::DATA_W-1:0] cross_reg;
    logic [bptc_pkg::COEF_W-1:0] c30_reg;

    bptc_pkg::reg_idx_t reg_idx;

    assign reg_idx = bptc_pkg::reg_idx_t'(paddr[bptc_pkg::APB_AW-1:bptc_pkg::IDX_LSB]);
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            press_osr_reg <= bptc_pkg::OSR_RESET;
            temp_osr_reg  <= bptc_pkg::OSR_RESET;
            c0_reg        <= '0;
            c1_reg        <= '0;
            c00_reg       <= '0;
            c10_reg       <= '0;
            cross_reg     <= '0;
            c30_reg       <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                bptc_pkg::REG_PRESS_OSR: press_osr_reg <= pwdata[bptc_pkg::CODE_W-1:0];
                bptc_pkg::REG_TEMP_OSR:  temp_osr_reg  <= pwdata[bptc_pkg::CODE_W-1:0];
                bptc_pkg::REG_T_OFFSET:  c0_reg        <= pwdata[bptc_pkg::C0_W-1:0];
                bptc_pkg::REG_T_SLOPE:   c1_reg        <= pwdata[bptc_pkg::C0_W-1:0];
                bptc_pkg::REG_P_OFFSET:  c00_reg       <= pwdata[bptc_pkg::C00_W-1:0];
                bptc_pkg::REG_P_LINEAR:  c10_reg       <= pwdata[bptc_pkg::C00_W-1:0];
                bptc_pkg::REG_P_CROSS:   cross_reg     <= pwdata;
                bptc_pkg::REG_P_CUBIC:   c30_reg       <= pwdata[bptc_pkg::COEF_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            bptc_pkg::REG_PRESS_OSR: prdata = bptc_pkg::DATA_W'(press_osr_reg);
            bptc_pkg::REG_TEMP_OSR:  prdata = bptc_pkg::DATA_W'(temp_osr_reg);
            bptc_pkg::REG_T_OFFSET:  prdata = bptc_pkg::DATA_W'(c0_reg);
            bptc_pkg::REG_T_SLOPE:   prdata = bptc_pkg::DATA_W'(c1_reg);
            bptc_pkg::REG_P_OFFSET:  prdata = bptc_pkg::DATA_W'(c00_reg);
            bptc_pkg::REG_P_LINEAR:  prdata = bptc_pkg::DATA_W'(c10_reg);
            bptc_pkg::REG_P_CROSS:   prdata = cross_reg;
            bptc_pkg::REG_P_CUBIC:   prdata = bptc_pkg::DATA_W'(c30_reg);
            default:                 prdata = '0;
        endcase
    end

    // Signed views of the coefficients.
    logic signed [bptc_pkg::C0_W-1:0]   c0, c1;
    logic signed [bptc_pkg::C00_W-1:0]  c00, c10;
    logic signed [bptc_pkg::COEF_W-1:0] c01, c11, c20, c21, c30;

    assign c0  = $signed(c0_reg);
    assign c1  = $signed(c1_reg);
    assign c00 = $signed(c00_reg);
    assign c10 = $signed(c10_reg);
    assign c01 = $signed(cross_reg[0*bptc_pkg::COEF_W +: bptc_pkg::COEF_W]);
    assign c11 = $signed(cross_reg[1*bptc_pkg::COEF_W +: bptc_pkg::COEF_W]);
    assign c20 = $signed(cross_reg[2*bptc_pkg::COEF_W +: bptc_pkg::COEF_W]);
    assign c21 = $signed(cross_reg[3*bptc_pkg::COEF_W +: bptc_pkg::COEF_W]);
    assign c30 = $signed(c30_reg);

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline advances whenever the output slot is
    // empty or is being emptied in this cycle.
    // ------------------------------------------------------------------
    logic              adv;
    logic [STAGES-1:0] stage_valid_reg;
    logic              m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else if (adv) begin
            stage_valid_reg <= {stage_valid_reg[STAGES-2:0], s_valid};
            m_valid_reg     <= stage_valid_reg[STAGES-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: magnitude and sign of the raw readings. Division then runs on
    // magnitudes, which gives truncation toward zero after the sign returns.
    // ------------------------------------------------------------------
    logic [bptc_pkg::MAG_W-1:0] t_x_next, p_x_next, t_x1_reg, p_x1_reg;
    logic                       t_neg1_reg, p_neg1_reg;

    always_comb begin
        t_x_next = s_raw_temp[bptc_pkg::RAW_W-1]  ? bptc_pkg::MAG_W'(-s_raw_temp)
                                                  : bptc_pkg::MAG_W'(s_raw_temp);
        p_x_next = s_raw_press[bptc_pkg::RAW_W-1] ? bptc_pkg::MAG_W'(-s_raw_press)
                                                  : bptc_pkg::MAG_W'(s_raw_press);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_x1_reg   <= t_x_next;
            p_x1_reg   <= p_x_next;
            t_neg1_reg <= s_raw_temp[bptc_pkg::RAW_W-1];
            p_neg1_reg <= s_raw_press[bptc_pkg::RAW_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: quotient by 2^k - 1 through a reciprocal multiply.
    // ------------------------------------------------------------------
    logic [bptc_pkg::PROD_W-1:0] t_prod, p_prod;
    logic [bptc_pkg::QUO_W-1:0]  t_a_next, p_a_next, t_a2_reg, p_a2_reg;
    logic [bptc_pkg::MAG_W-1:0]  t_x2_reg, p_x2_reg;
    logic                        t_neg2_reg, p_neg2_reg;

    always_comb begin
        t_prod = bptc_pkg::PROD_W'(t_x1_reg)
               * bptc_pkg::PROD_W'(bptc_pkg::RECIP_TAB[temp_osr_reg]);
        p_prod = bptc_pkg::PROD_W'(p_x1_reg)
               * bptc_pkg::PROD_W'(bptc_pkg::RECIP_TAB[press_osr_reg]);
        t_a_next = (temp_osr_reg == bptc_pkg::CODE_UNIT) ? bptc_pkg::QUO_W'(t_x1_reg)
                 : bptc_pkg::QUO_W'(t_prod[bptc_pkg::PROD_W-1:bptc_pkg::RECIP_SHIFT]);
        p_a_next = (press_osr_reg == bptc_pkg::CODE_UNIT) ? bptc_pkg::QUO_W'(p_x1_reg)
                 : bptc_pkg::QUO_W'(p_prod[bptc_pkg::PROD_W-1:bptc_pkg::RECIP_SHIFT]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_a2_reg   <= t_a_next;
            p_a2_reg   <= p_a_next;
            t_x2_reg   <= t_x1_reg;
            p_x2_reg   <= p_x1_reg;
            t_neg2_reg <= t_neg1_reg;
            p_neg2_reg <= p_neg1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: the remainder gives the fraction bits below the quotient, and
    // quotient and fraction are joined into the scaled magnitude.
    // ------------------------------------------------------------------
    logic [bptc_pkg::DIFF_W-1:0] t_ad, p_ad, t_rem, p_rem;
    logic [bptc_pkg::FRAC_W-1:0] t_f, p_f;
    logic [bptc_pkg::SMAG_W-1:0] t_m_next, p_m_next, t_m3_reg, p_m3_reg;
    logic                        t_neg3_reg, p_neg3_reg;

    always_comb begin
        t_ad  = (bptc_pkg::DIFF_W'(t_a2_reg) << bptc_pkg::LOG_TAB[temp_osr_reg])
              - bptc_pkg::DIFF_W'(t_a2_reg);
        p_ad  = (bptc_pkg::DIFF_W'(p_a2_reg) << bptc_pkg::LOG_TAB[press_osr_reg])
              - bptc_pkg::DIFF_W'(p_a2_reg);
        t_rem = bptc_pkg::DIFF_W'(t_x2_reg) - t_ad;
        p_rem = bptc_pkg::DIFF_W'(p_x2_reg) - p_ad;
        t_f   = bptc_pkg::frac_bits(temp_osr_reg,  t_rem[bptc_pkg::REM_W-1:0]);
        p_f   = bptc_pkg::frac_bits(press_osr_reg, p_rem[bptc_pkg::REM_W-1:0]);
        t_m_next = bptc_pkg::fine_step(temp_osr_reg)
                 ? bptc_pkg::SMAG_W'({t_a2_reg[bptc_pkg::FINE_A_W-1:0], t_f})
                 : bptc_pkg::SMAG_W'({t_a2_reg, t_f[bptc_pkg::COARSE_F_W-1:0]});
        p_m_next = bptc_pkg::fine_step(press_osr_reg)
                 ? bptc_pkg::SMAG_W'({p_a2_reg[bptc_pkg::FINE_A_W-1:0], p_f})
                 : bptc_pkg::SMAG_W'({p_a2_reg, p_f[bptc_pkg::COARSE_F_W-1:0]});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_m3_reg   <= t_m_next;
            p_m3_reg   <= p_m_next;
            t_neg3_reg <= t_neg2_reg;
            p_neg3_reg <= p_neg2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: restore the sign, giving Tsc and Psc in Q7.24.
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::SC_W-1:0] t_sc_next, p_sc_next, t_sc_reg, p_sc_reg;

    always_comb begin
        t_sc_next = t_neg3_reg ? -bptc_pkg::SC_W'(t_m3_reg) : bptc_pkg::SC_W'(t_m3_reg);
        p_sc_next = p_neg3_reg ? -bptc_pkg::SC_W'(p_m3_reg) : bptc_pkg::SC_W'(p_m3_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_sc_reg <= t_sc_next;
            p_sc_reg <= p_sc_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: first products.
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::SQ_W-1:0]   p2_next, tp_next, p2_5_reg, tp_reg;
    logic signed [bptc_pkg::PC10_W-1:0] pc10_next, pc10_reg;
    logic signed [bptc_pkg::P16_W-1:0]  tc01_next, pc30_next, tc21_next;
    logic signed [bptc_pkg::P16_W-1:0]  tc01_reg, pc30_reg, tc21_reg;
    logic signed [bptc_pkg::TC1_W-1:0]  tc1_next, tc1_reg;

    always_comb begin
        p2_next   = bptc_pkg::SQ_W'(p_sc_reg) * bptc_pkg::SQ_W'(p_sc_reg);
        tp_next   = bptc_pkg::SQ_W'(t_sc_reg) * bptc_pkg::SQ_W'(p_sc_reg);
        pc10_next = bptc_pkg::PC10_W'(p_sc_reg) * bptc_pkg::PC10_W'(c10);
        tc01_next = bptc_pkg::P16_W'(t_sc_reg) * bptc_pkg::P16_W'(c01);
        pc30_next = bptc_pkg::P16_W'(p_sc_reg) * bptc_pkg::P16_W'(c30);
        tc21_next = bptc_pkg::P16_W'(t_sc_reg) * bptc_pkg::P16_W'(c21);
        tc1_next  = bptc_pkg::TC1_W'(t_sc_reg) * bptc_pkg::TC1_W'(c1);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            p2_5_reg <= p2_next;
            tp_reg   <= tp_next;
            pc10_reg <= pc10_next;
            tc01_reg <= tc01_next;
            pc30_reg <= pc30_next;
            tc21_reg <= tc21_next;
            tc1_reg  <= tc1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: the second-order factor w = c20 + Psc*c30 + Tsc*c21 (grid
    // 2^-24), the linear part, the finished temperature, and the two halves
    // of Tsc*Psc times c11. The temperature cannot leave 32 bits, so it
    // needs no saturation.
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::W_W-1:0]    w_next, w_reg;
    logic signed [bptc_pkg::LIN_W-1:0]  lin_next, lin6_reg;
    logic signed [bptc_pkg::TV_W-1:0]   tval;
    logic signed [bptc_pkg::OUT_W-1:0]  temp_next;
    logic signed [bptc_pkg::SC_W-1:0]   tph;
    logic signed [bptc_pkg::SPLIT:0]    tpl;
    logic signed [bptc_pkg::P16_W-1:0]  tphc_next, tplc_next, tphc_reg, tplc_reg;
    logic signed [bptc_pkg::SQ_W-1:0]   p2_6_reg;
    logic signed [bptc_pkg::OUT_W-1:0]  temp6_reg;

    always_comb begin
        w_next    = (bptc_pkg::W_W'(c20) <<< bptc_pkg::FRAC_SH)
                  + bptc_pkg::W_W'(pc30_reg) + bptc_pkg::W_W'(tc21_reg);
        lin_next  = bptc_pkg::LIN_W'(pc10_reg) + bptc_pkg::LIN_W'(tc01_reg);
        tval      = (bptc_pkg::TV_W'(c0) <<< bptc_pkg::TEMP_ALIGN) + tc1_reg;
        temp_next = bptc_pkg::OUT_W'(tval >>> bptc_pkg::TEMP_SHIFT);
        tph       = $signed(tp_reg[bptc_pkg::SPLIT+bptc_pkg::SC_W-1:bptc_pkg::SPLIT]);
        tpl       = $signed({1'b0, tp_reg[bptc_pkg::SPLIT-1:0]});
        tphc_next = bptc_pkg::P16_W'(tph) * bptc_pkg::P16_W'(c11);
        tplc_next = bptc_pkg::P16_W'(tpl) * bptc_pkg::P16_W'(c11);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w_reg     <= w_next;
            lin6_reg  <= lin_next;
            temp6_reg <= temp_next;
            tphc_reg  <= tphc_next;
            tplc_reg  <= tplc_next;
            p2_6_reg  <= p2_5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: Psc^2 * w as four partial products, and Tsc*Psc*c11 joined.
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::SPLIT:0]     p2h, p2l;
    logic signed [bptc_pkg::W_SPLIT-1:0] wh;
    logic signed [bptc_pkg::W_SPLIT:0]   wl;
    logic signed [bptc_pkg::PP_W-1:0]    hh_next, hl_next, lh_next, ll_next;
    logic signed [bptc_pkg::PP_W-1:0]    hh_reg, hl_reg, lh_reg, ll_reg;
    logic signed [bptc_pkg::TPC_W-1:0]   tpc_next, tpc7_reg;
    logic signed [bptc_pkg::LIN_W-1:0]   lin7_reg;
    logic signed [bptc_pkg::OUT_W-1:0]   temp7_reg;

    always_comb begin
        // Psc^2 is never negative and stays below 2^60.
        p2h = $signed({1'b0, p2_6_reg[2*bptc_pkg::SPLIT-1:bptc_pkg::SPLIT]});
        p2l = $signed({1'b0, p2_6_reg[bptc_pkg::SPLIT-1:0]});
        wh  = w_reg[bptc_pkg::W_W-1:bptc_pkg::W_SPLIT];
        wl  = $signed({1'b0, w_reg[bptc_pkg::W_SPLIT-1:0]});
        hh_next  = bptc_pkg::PP_W'(p2h) * bptc_pkg::PP_W'(wh);
        hl_next  = bptc_pkg::PP_W'(p2h) * bptc_pkg::PP_W'(wl);
        lh_next  = bptc_pkg::PP_W'(p2l) * bptc_pkg::PP_W'(wh);
        ll_next  = bptc_pkg::PP_W'(p2l) * bptc_pkg::PP_W'(wl);
        tpc_next = (bptc_pkg::TPC_W'(tphc_reg) <<< bptc_pkg::SPLIT)
                 + bptc_pkg::TPC_W'(tplc_reg);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hh_reg    <= hh_next;
            hl_reg    <= hl_next;
            lh_reg    <= lh_next;
            ll_reg    <= ll_next;
            tpc7_reg  <= tpc_next;
            lin7_reg  <= lin6_reg;
            temp7_reg <= temp6_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stages 8 to 10: align everything on the 2^-72 grid and add it up.
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::ACC_W-1:0] pwa_next, pwb_next, basea_next;
    logic signed [bptc_pkg::ACC_W-1:0] pwa_reg, pwb_reg, basea_reg;
    logic signed [bptc_pkg::TPC_W-1:0] tpc8_reg;
    logic signed [bptc_pkg::OUT_W-1:0] temp8_reg;

    always_comb begin
        pwa_next   = (bptc_pkg::ACC_W'(hh_reg) <<< (bptc_pkg::SPLIT + bptc_pkg::W_SPLIT))
                   + (bptc_pkg::ACC_W'(hl_reg) <<< bptc_pkg::SPLIT);
        pwb_next   = (bptc_pkg::ACC_W'(lh_reg) <<< bptc_pkg::W_SPLIT)
                   + bptc_pkg::ACC_W'(ll_reg);
        basea_next = (bptc_pkg::ACC_W'(c00) <<< (3*bptc_pkg::FRAC_SH))
                   + (bptc_pkg::ACC_W'(lin7_reg) <<< (2*bptc_pkg::FRAC_SH));
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pwa_reg   <= pwa_next;
            pwb_reg   <= pwb_next;
            basea_reg <= basea_next;
            tpc8_reg  <= tpc7_reg;
            temp8_reg <= temp7_reg;
        end
    end

    logic signed [bptc_pkg::ACC_W-1:0] pw_next, base_next, pw_reg, base_reg;
    logic signed [bptc_pkg::OUT_W-1:0] temp9_reg;

    always_comb begin
        pw_next   = pwa_reg + pwb_reg;
        base_next = basea_reg + (bptc_pkg::ACC_W'(tpc8_reg) <<< bptc_pkg::FRAC_SH);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pw_reg    <= pw_next;
            base_reg  <= base_next;
            temp9_reg <= temp8_reg;
        end
    end

    logic signed [bptc_pkg::ACC_W-1:0] acc_next, acc_reg;
    logic signed [bptc_pkg::OUT_W-1:0] temp10_reg;

    assign acc_next = pw_reg + base_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            acc_reg    <= acc_next;
            temp10_reg <= temp9_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: floor to 1/64 Pa and saturate to 32 bits.
    // ------------------------------------------------------------------
    logic signed [bptc_pkg::Q_W-1:0]   q;
    logic                              q_fits;
    logic signed [bptc_pkg::OUT_W-1:0] press_next, m_pressure_reg, m_temperature_reg;
    logic                              m_clipped_reg;

    always_comb begin
        q      = bptc_pkg::Q_W'(acc_reg >>> bptc_pkg::ACC_SHIFT);
        q_fits = (&q[bptc_pkg::Q_W-1:bptc_pkg::OUT_W-1]) || !(|q[bptc_pkg::Q_W-1:bptc_pkg::OUT_W-1]);
        if (q_fits) begin
            press_next = q[bptc_pkg::OUT_W-1:0];
        end else if (q[bptc_pkg::Q_W-1]) begin
            press_next = bptc_pkg::OUT_MIN;
        end else begin
            press_next = bptc_pkg::OUT_MAX;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_pressure_reg    <= press_next;
            m_temperature_reg <= temp10_reg;
            m_clipped_reg     <= !q_fits;
        end
    end

    assign m_pressure    = m_pressure_reg;
    assign m_temperature = m_temperature_reg;
    assign m_clipped     = m_clipped_reg;

endmodule

/* sim/baro_comp_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// Compensation result checker
// Follows the register writes on the APB port and predicts, for every sample
// word taken, the compensated temperature, pressure and clipped flag. Result
// words are compared in order with those predictions.
// ============================================================================
module baro_comp_checker
    import bptc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_valid,
    input  logic                        s_ready,
    input  logic signed [RAW_W-1:0]     s_raw_temp,
    input  logic signed [RAW_W-1:0]     s_raw_press,

    input  logic                        m_valid,
    input  logic                        m_ready,
    input  logic signed [OUT_W-1:0]     m_temperature,
    input  logic signed [OUT_W-1:0]     m_pressure,
    input  logic                        m_clipped,

    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_AW-1:0]           paddr,
    input  logic [DATA_W-1:0]           pwdata,
    input  logic                        pready,

    output int                          mismatch_count,
    output int                          readings_pending
);

    // Wide enough to hold the pressure sum on its 2^-72 grid without loss.
    typedef logic signed [127:0] exact_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] temperature;
        logic signed [OUT_W-1:0] pressure;
        logic                    clipped;
    } reading_t;

    localparam longint SCALE_FACTOR [8] = '{
        524288, 1572864, 3670016, 7864320, 253952, 516096, 1040384, 2088960
    };

    localparam int PRINT_LIMIT = 100;

    // Shadow copy of the calibration registers.
    logic [CODE_W-1:0]         press_code;
    logic [CODE_W-1:0]         temp_code;
    logic signed [C0_W-1:0]    t_off;
    logic signed [C0_W-1:0]    t_slope;
    logic signed [C00_W-1:0]   p_off;
    logic signed [C00_W-1:0]   p_lin;
    logic signed [COEF_W-1:0]  c01;
    logic signed [COEF_W-1:0]  c11;
    logic signed [COEF_W-1:0]  c20;
    logic signed [COEF_W-1:0]  c21;
    logic signed [COEF_W-1:0]  c30;

    reading_t expected_readings [$];
    int       fails         = 0;
    int       in_flight     = 0;
    int       lines_printed = 0;

    assign mismatch_count   = fails;
    assign readings_pending = in_flight;

    function automatic logic signed [OUT_W-1:0] saturate_word(input exact_t v,
                                                             inout logic clip);
        if (v > 128'sd2147483647) begin
            clip = 1'b1;
            return OUT_MAX;
        end
        if (v < -128'sd2147483648) begin
            clip = 1'b1;
            return OUT_MIN;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic reading_t compensate_pair(input logic signed [RAW_W-1:0] raw_t,
                                                 input logic signed [RAW_W-1:0] raw_p);
        longint   tsc;
        longint   psc;
        longint   t_fine;
        exact_t   wt;
        exact_t   wp;
        exact_t   k00;
        exact_t   k10;
        exact_t   k01;
        exact_t   k11;
        exact_t   k20;
        exact_t   k21;
        exact_t   k30;
        exact_t   acc;
        exact_t   t_wide;
        logic     clip;
        reading_t r;

        // Q7.24 scaled readings, division truncating toward zero.
        tsc = (longint'(raw_t) * 64'sd16777216) / SCALE_FACTOR[temp_code];
        psc = (longint'(raw_p) * 64'sd16777216) / SCALE_FACTOR[press_code];

        t_fine = longint'(t_off) * 64'sd8388608 + longint'(t_slope) * tsc;

        wt  = exact_t'(tsc);
        wp  = exact_t'(psc);
        k00 = exact_t'(p_off);
        k10 = exact_t'(p_lin);
        k01 = exact_t'(c01);
        k11 = exact_t'(c11);
        k20 = exact_t'(c20);
        k21 = exact_t'(c21);
        k30 = exact_t'(c30);
        acc = (k00 <<< 72) + ((wp * k10) <<< 48) + ((wp * wp * k20) <<< 24)
            + wp * wp * wp * k30 + ((wt * k01) <<< 48) + ((wt * wp * k11) <<< 24)
            + wp * wp * wt * k21;

        clip          = 1'b0;
        t_wide        = exact_t'(t_fine >>> TEMP_SHIFT);
        r.temperature = saturate_word(t_wide, clip);
        r.pressure    = saturate_word(acc >>> ACC_SHIFT, clip);
        r.clipped     = clip;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (lines_printed < PRINT_LIMIT) begin
            $display("[%0t] MISMATCH %s", $time, msg);
            lines_printed++;
        end
        fails++;
    endtask

    always @(posedge aclk) begin : watch
        reading_t want;
        if (!aresetn) begin
            expected_readings.delete();
            press_code = OSR_RESET;
            temp_code  = OSR_RESET;
            t_off      = '0;
            t_slope    = '0;
            p_off      = '0;
            p_lin      = '0;
            c01        = '0;
            c11        = '0;
            c20        = '0;
            c21        = '0;
            c30        = '0;
        end else begin
            if (s_valid && s_ready)
                expected_readings.push_back(compensate_pair(s_raw_temp, s_raw_press));

            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("result word with no sample outstanding");
                end else begin
                    want = expected_readings.pop_front();
                    if (m_temperature !== want.temperature)
                        report_mismatch($sformatf("temperature got %0d want %0d",
                                                  m_temperature, want.temperature));
                    if (m_pressure !== want.pressure)
                        report_mismatch($sformatf("pressure got %0d want %0d",
                                                  m_pressure, want.pressure));
                    if (m_clipped !== want.clipped)
                        report_mismatch($sformatf("clipped got %b want %b",
                                                  m_clipped, want.clipped));
                end
            end

            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[APB_AW-1:IDX_LSB]))
                    REG_PRESS_OSR: press_code = pwdata[CODE_W-1:0];
                    REG_TEMP_OSR:  temp_code  = pwdata[CODE_W-1:0];
                    REG_T_OFFSET:  t_off      = pwdata[C0_W-1:0];
                    REG_T_SLOPE:   t_slope    = pwdata[C0_W-1:0];
                    REG_P_OFFSET:  p_off      = pwdata[C00_W-1:0];
                    REG_P_LINEAR:  p_lin      = pwdata[C00_W-1:0];
                    REG_P_CROSS: begin
                        c01 = pwdata[0*COEF_W +: COEF_W];
                        c11 = pwdata[1*COEF_W +: COEF_W];
                        c20 = pwdata[2*COEF_W +: COEF_W];
                        c21 = pwdata[3*COEF_W +: COEF_W];
                    end
                    REG_P_CUBIC:   c30        = pwdata[COEF_W-1:0];
                    default: ;
                endcase
            end
        end
        in_flight = expected_readings.size();
    end

endmodule

/* sim/baro_pressure_temp_compensation_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// Barometric compensation testbench
// Drives raw temperature and pressure words into the compensation pipeline
// under a series of calibration settings, with random gaps on the input and
// random back-pressure on the output, and gives the verdict of the checker.
// ============================================================================
module baro_pressure_temp_compensation_test;

    import bptc_pkg::*;

    localparam logic signed [RAW_W-1:0] RAW_MAX = 24'sh7FFFFF;
    localparam logic signed [RAW_W-1:0] RAW_MIN = 24'sh800000;

    // Random part: a number of calibration settings, each with its own run of
    // sample words. The last setting runs with no idling on either side.
    localparam int RANDOM_SETTINGS   = 10;
    localparam int WORDS_PER_SETTING = 115;

    // Quiet time allowed once the last expected word has arrived.
    localparam int DRAIN_CYCLES = 16;

    logic                       aclk        = 1'b0;
    logic                       aresetn     = 1'b0;
    logic                       s_valid     = 1'b0;
    logic                       s_ready;
    logic signed [RAW_W-1:0]    s_raw_temp  = '0;
    logic signed [RAW_W-1:0]    s_raw_press = '0;
    logic                       m_valid;
    logic                       m_ready     = 1'b0;
    logic signed [OUT_W-1:0]    m_temperature;
    logic signed [OUT_W-1:0]    m_pressure;
    logic                       m_clipped;
    logic                       psel        = 1'b0;
    logic                       penable     = 1'b0;
    logic                       pwrite      = 1'b0;
    logic [APB_AW-1:0]          paddr       = '0;
    logic [DATA_W-1:0]          pwdata      = '0;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;

    int mismatch_count;
    int readings_pending;

    // Idling odds in percent, changed from one setting to the next.
    int gap_pct   = 0;
    int stall_pct = 0;

    // Register values for the next setting, indexed by register.
    logic [DATA_W-1:0] settings [8];

    baro_pressure_temp_compensation dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_temp    (s_raw_temp),
        .s_raw_press   (s_raw_press),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_temperature (m_temperature),
        .m_pressure    (m_pressure),
        .m_clipped     (m_clipped),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    baro_comp_checker comp_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_raw_temp       (s_raw_temp),
        .s_raw_press      (s_raw_press),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_temperature    (m_temperature),
        .m_pressure       (m_pressure),
        .m_clipped        (m_clipped),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .pready           (pready),
        .mismatch_count   (mismatch_count),
        .readings_pending (readings_pending)
    );

    // 100 MHz clock; rising edges fall on odd multiples of 5 ns.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog. The slowest legal run is about a tenth of this: about
    // 1200 words, each at worst with the longest input gap and output stall.
    initial begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver back-pressure: m_ready is held high or low for bursts of
    // random length. Each pass through the loop makes exactly one assignment
    // and then lets falling edges go by before the next one.
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(0, 11)) @(negedge aclk);
            end
        end
    end

    // Fills the bits above a register's width with noise; the block is meant
    // to ignore them.
    function automatic logic [DATA_W-1:0] with_junk(input logic [DATA_W-1:0] v,
                                                    input int w);
        logic [DATA_W-1:0] junk;
        logic [DATA_W-1:0] mask;
        if (w >= DATA_W)
            return v;
        junk = {$urandom(), $urandom()};
        mask = (64'd1 << w) - 64'd1;
        return (junk & ~mask) | (v & mask);
    endfunction

    // A signed coefficient of width w: anything at all, one of the two
    // extremes, or a small value near zero that keeps the sums realistic.
    function automatic logic [DATA_W-1:0] pick_coef(input int w);
        logic [DATA_W-1:0] v;
        int                tmp;
        case ($urandom_range(0, 2))
            0: v = {$urandom(), $urandom()};
            1: v = $urandom_range(0, 1) ? (64'd1 << (w - 1)) - 64'd1 : 64'd1 << (w - 1);
            default: begin
                tmp = int'($urandom_range(0, (1 << (w / 2 + 1)) - 1)) - (1 << (w / 2));
                v   = DATA_W'(tmp);
            end
        endcase
        return with_junk(v, w);
    endfunction

    function automatic logic signed [RAW_W-1:0] random_raw();
        logic signed [RAW_W-1:0] r;
        case ($urandom_range(0, 9))
            0, 1: begin
                case ($urandom_range(0, 3))
                    0:       r = RAW_MAX;
                    1:       r = RAW_MIN;
                    2:       r = '0;
                    default: r = '1;
                endcase
            end
            2, 3, 4: r = RAW_W'(int'($urandom_range(0, 8191)) - 4096);
            default: r = RAW_W'($urandom());
        endcase
        return r;
    endfunction

    // One APB write: setup cycle, then access cycle until pready. The bus is
    // left idle before the task returns, so that back-to-back calls never
    // assign psel twice in one time step.
    task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << IDX_LSB;
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_settings();
        for (int i = 0; i < 8; i++)
            apb_write(reg_idx_t'(i), settings[i]);
    endtask

    // Presents one sample word and holds it until it is taken, then perhaps
    // leaves a gap. Called and returning on a falling edge.
    task automatic feed_pair(input logic signed [RAW_W-1:0] raw_t,
                             input logic signed [RAW_W-1:0] raw_p);
        s_valid     <= 1'b1;
        s_raw_temp  <= raw_t;
        s_raw_press <= raw_p;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
            s_valid     <= 1'b0;
            s_raw_temp  <= RAW_W'($urandom());
            s_raw_press <= RAW_W'($urandom());
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    endtask

    // Waits until every word taken has come back and the pipeline is empty,
    // so that the registers may safely be rewritten.
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (readings_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Extremes and sign boundaries of both raw fields.
    task automatic feed_corner_pairs();
        feed_pair(RAW_MAX, RAW_MAX);
        feed_pair(RAW_MIN, RAW_MIN);
        feed_pair(RAW_MAX, RAW_MIN);
        feed_pair(RAW_MIN, RAW_MAX);
        feed_pair('0, '0);
        feed_pair(-1, -1);
        feed_pair(1, 1);
        feed_pair(RAW_MAX, '0);
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        gap_pct   = 30;
        stall_pct = 30;

        // Reset settings: all coefficients are zero, so everything reads zero.
        feed_pair(RAW_MAX, RAW_MIN);
        feed_pair(RAW_MIN, RAW_MAX);
        settle_pipeline();

        // Largest positive coefficients with the smallest scale factors: the
        // extremes of the raw words drive both saturation limits.
        settings = '{
            with_junk(4, CODE_W), with_junk(5, CODE_W),
            with_junk(2047, C0_W), with_junk(2047, C0_W),
            with_junk(524287, C00_W), with_junk(524287, C00_W),
            64'h7FFF_7FFF_7FFF_7FFF, with_junk(32767, COEF_W)
        };
        write_settings();
        feed_corner_pairs();
        settle_pipeline();

        // Most negative coefficients, coarsest pressure and finest
        // temperature codes.
        settings = '{
            with_junk(0, CODE_W), with_junk(7, CODE_W),
            with_junk(-2048, C0_W), with_junk(-2048, C0_W),
            with_junk(-524288, C00_W), with_junk(-524288, C00_W),
            64'h8000_8000_8000_8000, with_junk(-32768, COEF_W)
        };
        write_settings();
        feed_corner_pairs();
        settle_pipeline();

        // Coefficients of a plausible sensor, where nothing should clip and
        // the flooring of negative values matters.
        settings = '{
            with_junk(7, CODE_W), with_junk(0, CODE_W),
            with_junk(400, C0_W), with_junk(-300, C0_W),
            with_junk(80000, C00_W), with_junk(-60000, C00_W),
            {16'(120), 16'(-7000), 16'(1500), 16'(-2500)}, with_junk(-40, COEF_W)
        };
        write_settings();
        feed_pair(200000, -3000000);
        feed_pair(-200000, 3000000);
        feed_pair(-1, 1);
        feed_pair(1, -1);
        settle_pipeline();

        for (int ph = 0; ph < RANDOM_SETTINGS; ph++) begin
            settings = '{
                with_junk(DATA_W'($urandom_range(0, 7)), CODE_W),
                with_junk(DATA_W'($urandom_range(0, 7)), CODE_W),
                pick_coef(C0_W), pick_coef(C0_W),
                pick_coef(C00_W), pick_coef(C00_W),
                64'd0, pick_coef(COEF_W)
            };
            for (int k = 0; k < 4; k++)
                settings[REG_P_CROSS][k*COEF_W +: COEF_W] = COEF_W'(pick_coef(COEF_W));
            write_settings();

            // Each setting draws its own idling mood; some run flat out.
            if (ph == RANDOM_SETTINGS - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 20;
                    default: gap_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    default: stall_pct = 50;
                endcase
            end

            repeat (WORDS_PER_SETTING) feed_pair(random_raw(), random_raw());
            settle_pipeline();
        end

        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
